### rtl/twrq_pkg.sv
`timescale 1ns / 1ps
package twrq_pkg;

   localparam int CHIP_W      = 3;
   localparam int CHIP_SLOTS  = 8;
   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 8;
   localparam int FIELD_TIME_W = 32;
   localparam int MAX_RESULTS = 32;
   localparam int RESULT_N_W  = 6;
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = 2;
   localparam int RSP_CNT_W   = 3;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_SERVICE = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_RESET   = 2'd3
   } op_type;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_RESET  = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   typedef struct packed {
      op_type                  op;
      logic [CHIP_W-1:0]       chip;
      logic [FIELD_TIME_W-1:0] wtime;
      logic [ADDR_W-1:0]       addr;
      logic [DATA_W-1:0]       data;
      logic [FIELD_TIME_W-1:0] now;
   } cmd_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [CHIP_W-1:0] chip;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic              last;
   } rsp_type;

endpackage

### rtl/twrq_front.sv
`timescale 1ns / 1ps
module twrq_front #(
   parameter int NUM_CHIPS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  twrq_pkg::cmd_type cmd_in,
   output logic              cmd_valid,
   output twrq_pkg::cmd_type cmd_out,
   input  logic              cmd_pop
);
   import twrq_pkg::*;

   cmd_type    slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       keep;
   logic       do_push;
   logic       do_pop;

   // Items other than service items for a chip that does not exist are taken and dropped here.
   always_comb begin
      keep = (cmd_in.op == OP_SERVICE) ||
             ({26'd0, cmd_in.chip} < NUM_CHIPS[28:0]);
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_out   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full && keep;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

### rtl/twrq_rsp_fifo.sv
`timescale 1ns / 1ps
module twrq_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  twrq_pkg::rsp_type push_data,
   output logic              full,
   output logic              empty,
   output twrq_pkg::rsp_type head,
   input  logic              pop
);
   import twrq_pkg::*;

   rsp_type              slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (cnt_ff == RSP_CNT_W'(RSP_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(do_pop);
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(do_push);
      cnt_in    = cnt_ff + RSP_CNT_W'(do_push) - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/twrq_back.sv
`timescale 1ns / 1ps
module twrq_back #(
   parameter int QUEUE_DEPTH = 32,
   parameter int TIME_BITS   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  twrq_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              out_full,
   output logic              out_push,
   output twrq_pkg::rsp_type out_data
);
   import twrq_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [CHIP_W-1:0]    chip;
      logic [TIME_BITS-1:0] etime;
      logic [ADDR_W-1:0]    addr;
      logic [DATA_W-1:0]    data;
   } entry_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DRD  = 7'b0000010,
      ST_DEV  = 7'b0000100,
      ST_DFIN = 7'b0001000,
      ST_CRD  = 7'b0010000,
      ST_CEV  = 7'b0100000,
      ST_CFIN = 7'b1000000
   } state_type;

   function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] sum;
      sum = {{(CW+1-PW){1'b0}}, a} + {1'b0, b};
      if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CW+1)'(QUEUE_DEPTH);
      end
      return sum[PW-1:0];
   endfunction

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;
   logic [PW-1:0] rd_addr;
   logic          mem_we;
   logic [PW-1:0] wr_addr;
   entry_type     wr_entry;

   state_type           state_ff, state_in;
   logic [PW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       pend_ff [CHIP_SLOTS];
   logic [CW-1:0]       pend_in [CHIP_SLOTS];
   cmd_type             cur_ff, cur_in;
   logic [RESULT_N_W-1:0] n_ff, n_in;
   entry_type           held_ff, held_in;
   logic                held_v_ff, held_v_in;
   logic [CW-1:0]       r_ff, r_in;
   logic [CW-1:0]       w_ff, w_in;
   logic [TIME_BITS-1:0] cmd_wt;
   logic [TIME_BITS-1:0] cmd_now;
   logic [TIME_BITS-1:0] cur_now;

   assign cmd_wt  = TIME_BITS'(cmd.wtime);
   assign cmd_now = TIME_BITS'(cmd.now);
   assign cur_now = TIME_BITS'(cur_ff.now);
   assign rd_addr = (state_ff == ST_CRD) ? ptr_add(head_ff, r_ff) : head_ff;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      pend_in   = pend_ff;
      cur_in    = cur_ff;
      n_in      = n_ff;
      held_in   = held_ff;
      held_v_in = held_v_ff;
      r_in      = r_ff;
      w_in      = w_ff;
      cmd_pop   = 1'b0;
      out_push  = 1'b0;
      out_data  = '0;
      mem_we    = 1'b0;
      wr_addr   = ptr_add(head_ff, count_ff);
      wr_entry  = '{chip: cmd.chip, etime: cmd_wt, addr: cmd.addr, data: cmd.data};
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !out_full) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               case (cmd.op)
                  OP_WRITE: begin
                     if (pend_ff[cmd.chip] == '0 && cmd_wt < cmd_now) begin
                        out_push = 1'b1;
                        out_data = '{kind: KIND_WRITE, chip: cmd.chip, addr: cmd.addr,
                                     data: cmd.data, last: 1'b1};
                     end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                        out_push = 1'b1;
                        out_data = '{kind: KIND_REJECT, chip: cmd.chip, addr: cmd.addr,
                                     data: cmd.data, last: 1'b1};
                     end else begin
                        mem_we             = 1'b1;
                        count_in           = count_ff + 1'b1;
                        pend_in[cmd.chip]  = pend_ff[cmd.chip] + 1'b1;
                     end
                  end
                  OP_SERVICE: begin
                     n_in      = '0;
                     held_v_in = 1'b0;
                     if (count_ff != '0) begin
                        state_in = ST_DRD;
                     end
                  end
                  default: begin
                     r_in     = '0;
                     w_in     = '0;
                     state_in = (count_ff != '0) ? ST_CRD : ST_CFIN;
                  end
               endcase
            end
         end
         ST_DRD: begin
            state_in = ST_DEV;
         end
         ST_DEV: begin
            if (rd_data_ff.etime <= cur_now) begin
               if (!(held_v_ff && out_full)) begin
                  if (held_v_ff) begin
                     out_push = 1'b1;
                     out_data = '{kind: KIND_WRITE, chip: held_ff.chip, addr: held_ff.addr,
                                  data: held_ff.data, last: 1'b0};
                  end
                  head_in   = ptr_add(head_ff, CW'(1));
                  count_in  = count_ff - 1'b1;
                  if (pend_ff[rd_data_ff.chip] != '0) begin
                     pend_in[rd_data_ff.chip] = pend_ff[rd_data_ff.chip] - 1'b1;
                  end
                  n_in      = n_ff + 1'b1;
                  held_in   = rd_data_ff;
                  held_v_in = 1'b1;
                  if (count_ff == CW'(1) || n_ff == RESULT_N_W'(MAX_RESULTS - 1)) begin
                     state_in = ST_DFIN;
                  end else begin
                     state_in = ST_DRD;
                  end
               end
            end else begin
               state_in = held_v_ff ? ST_DFIN : ST_IDLE;
            end
         end
         ST_DFIN: begin
            if (!out_full) begin
               out_push = 1'b1;
               out_data = '{kind: KIND_WRITE, chip: held_ff.chip, addr: held_ff.addr,
                            data: held_ff.data, last: 1'b1};
               state_in = ST_IDLE;
            end
         end
         ST_CRD: begin
            state_in = ST_CEV;
         end
         ST_CEV: begin
            if (rd_data_ff.chip != cur_ff.chip) begin
               mem_we   = 1'b1;
               wr_addr  = ptr_add(head_ff, w_ff);
               wr_entry = rd_data_ff;
               w_in     = w_ff + 1'b1;
            end
            r_in     = r_ff + 1'b1;
            state_in = (r_ff + 1'b1 == count_ff) ? ST_CFIN : ST_CRD;
         end
         ST_CFIN: begin
            if (!(cur_ff.op == OP_RESET && out_full)) begin
               if (cur_ff.op == OP_RESET) begin
                  out_push = 1'b1;
                  out_data = '{kind: KIND_RESET, chip: cur_ff.chip, addr: '0,
                               data: '0, last: 1'b1};
               end
               count_in              = w_ff;
               pend_in[cur_ff.chip]  = '0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         pend_ff   <= '{default: '0};
         held_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         held_v_ff <= held_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      n_ff    <= n_in;
      held_ff <= held_in;
      r_ff    <= r_in;
      w_ff    <= w_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

### rtl/timed_register_write_queue_top.sv
`timescale 1ns / 1ps
// A write that passes straight through or is rejected has its result pushed to the result
// queue by the back end once it leaves the command buffer; a queued write gives no result.
// A service item drains entries one at a time, and a clear or chip reset reads each queued
// entry in turn, as set by the single read port of the entry memory. A full result queue
// holds up the back end for as long as it stays full.
// Reset is synchronous, active high; it empties all three queues and zeroes pending counts.
module timed_register_write_queue_top #(
   parameter int QUEUE_DEPTH = 32,
   parameter int NUM_CHIPS   = 8,
   parameter int TIME_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_chip_id,
   input  logic [31:0] req_write_time,
   input  logic [15:0] req_reg_addr,
   input  logic [7:0]  req_reg_data,
   input  logic [31:0] req_current_time,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_out_chip,
   output logic [15:0] rsp_out_addr,
   output logic [7:0]  rsp_out_data,
   output logic        rsp_last
);
   import twrq_pkg::*;

   cmd_type req_cmd;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    out_full;
   logic    out_push;
   rsp_type out_data;
   rsp_type rsp_head;

   assign req_cmd = '{op: op_type'(req_mode), chip: req_chip_id, wtime: req_write_time,
                      addr: req_reg_addr, data: req_reg_data, now: req_current_time};

   twrq_front #(.NUM_CHIPS(NUM_CHIPS)) u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .cmd_in(req_cmd),
      .cmd_valid(cmd_valid), .cmd_out(cmd), .cmd_pop(cmd_pop)
   );

   twrq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
      .out_full(out_full), .out_push(out_push), .out_data(out_data)
   );

   twrq_rsp_fifo u_rsp (
      .clock(clock), .reset(reset), .push(out_push), .push_data(out_data),
      .full(out_full), .empty(empty), .head(rsp_head), .pop(pop)
   );

   assign rsp_kind     = rsp_head.kind;
   assign rsp_out_chip = rsp_head.chip;
   assign rsp_out_addr = rsp_head.addr;
   assign rsp_out_data = rsp_head.data;
   assign rsp_last     = rsp_head.last;

endmodule
